/* sv/bloom_filter_fnv_double_hash_macros.svh */
// Assertion macros shared by the Bloom filter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BLOOM_FILTER_FNV_DOUBLE_HASH_MACROS_SVH
`define BLOOM_FILTER_FNV_DOUBLE_HASH_MACROS_SVH
`ifndef ASSERT_OFF
`define BFD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("bloom filter assertion failed");
`define BFD_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bloom filter assertion failed");
`else
`define BFD_ASSERT(lbl, clk, rstn, prop)
`define BFD_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

/* sv/fnvbf_pkg.sv */
// Package for the FNV double-hash Bloom filter: constants, codes, types, mix function.
// No dependencies.
package fnvbf_pkg;

	localparam int STORE_WORDS = 2048;
	localparam int WORD_AW = 11;

	localparam logic [16:0] MAX_BITS = 17'd65536;
	localparam logic [4:0] MAX_HASHES = 5'd16;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;

	// input item kinds
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_TEST = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ = 2'd3;

	// result kinds
	localparam logic [1:0] ANS_ADD = 2'd0;
	localparam logic [1:0] ANS_TEST = 2'd1;
	localparam logic [1:0] ANS_READ = 2'd2;

	// configuration register indexes
	localparam logic CFG_BIT_COUNT = 1'b0;
	localparam logic CFG_HASH_COUNT = 1'b1;

	localparam logic [2:0] MIX_LAST_ROUND = 3'd4;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MIX,
		S_MULB,
		S_MOD,
		S_RD,
		S_RDW,
		S_WRD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] rem;
	} mod_rsp_t;

	// one shift-add or shift-xor round of the mixer
	function automatic logic [31:0] mix_round(input logic [31:0] v, input logic [2:0] r);
		logic [31:0] res;
		case (r)
			3'd0: res = v + (v << 13);
			3'd1: res = v ^ (v >> 7);
			3'd2: res = v + (v << 3);
			3'd3: res = v ^ (v >> 17);
			default: res = v + (v << 5);
		endcase
		return res;
	endfunction

endpackage

/* sv/fnvbf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fnvbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/fnvbf_mod.sv */
// Restoring remainder unit: 32-bit dividend modulo a 17-bit divisor, one bit per cycle.
// Depends on fnvbf_pkg.
module fnvbf_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  fnvbf_pkg::mod_req_t req,
	output fnvbf_pkg::mod_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] num_q;
	logic [15:0] rem_q;
	logic [16:0] div_q;
	logic [16:0] trial;
	logic        fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, num_q[31]};
	assign fits = trial >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? 16'(trial - div_q) : trial[15:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem = rem_q;

endmodule

/* sv/bloom_filter_fnv_double_hash.sv */
// Bloom filter over 2048 words of 32 bits, keys hashed one byte per transaction (FNV-1a,
// byte sign-extended). After reset the store is cleared one word per cycle before any item
// is taken. A key byte takes one multiply. A last item runs five mixer rounds, a multiply and
// five more (only the first five when the bit count is zero), then per probe the bit-serial
// remainder unit and one store read-modify-write. Word writes complete in idle. Depends on
// fnvbf_pkg, fnvbf_mod, fnvbf_ram and bloom_filter_fnv_double_hash_macros.svh.
`include "bloom_filter_fnv_double_hash_macros.svh"
module bloom_filter_fnv_double_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  key_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic [10:0] word_index,
	input  logic [31:0] word_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  answer_kind,
	output logic        probably_present,
	output logic [31:0] read_word
);

	fnvbf_pkg::state_t state_q, state_d;

	logic [16:0] bit_count_q;
	logic [4:0]  hash_count_q;
	logic [16:0] n_eff;
	logic [4:0]  k_eff;

	logic [31:0] acc_q, mul_in_q, val_q, a_q, b_q, word_q;
	logic [31:0] prod, mixed, ext, mask;
	logic [2:0]  rnd_q;
	logic        phase_q, last_q, present_q;
	logic [1:0]  kind_q;
	logic [15:0] x_q;
	logic [4:0]  probe_q;
	logic [10:0] clr_q;
	logic        in_acc;
	logic        mix_end, probe_end, out_free;

	logic        out_valid_q, present_out_q;
	logic [1:0]  answer_kind_q;
	logic [31:0] read_word_q;

	logic        ram_we;
	logic [10:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	fnvbf_pkg::mod_req_t mod_req;
	fnvbf_pkg::mod_rsp_t mod_rsp;

	// saturated configuration
	assign n_eff = (bit_count_q > fnvbf_pkg::MAX_BITS) ? fnvbf_pkg::MAX_BITS : bit_count_q;
	assign k_eff = (hash_count_q > fnvbf_pkg::MAX_HASHES) ? fnvbf_pkg::MAX_HASHES
		: hash_count_q;

	// shared multiplier, mixer round and probe helpers
	assign prod = mul_in_q * fnvbf_pkg::FNV_PRIME;
	assign mixed = fnvbf_pkg::mix_round(val_q, rnd_q);
	assign ext = {{24{key_byte[7]}}, key_byte};
	assign mask = 32'd1 << x_q[4:0];
	assign mix_end = rnd_q == fnvbf_pkg::MIX_LAST_ROUND;
	assign probe_end = (probe_q + 5'd1) == k_eff;
	assign out_free = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
			hash_count_q <= 5'd1;
		end else if (cfg_write) begin
			if (cfg_index == fnvbf_pkg::CFG_BIT_COUNT) begin
				bit_count_q <= cfg_data;
			end else begin
				hash_count_q <= cfg_data[4:0];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fnvbf_pkg::S_CLEAR: begin
				if (clr_q == 11'h7FF) begin
					state_d = fnvbf_pkg::S_IDLE;
				end
			end
			fnvbf_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						fnvbf_pkg::KIND_WRITE: state_d = fnvbf_pkg::S_IDLE;
						fnvbf_pkg::KIND_READ: state_d = fnvbf_pkg::S_WRD;
						default: begin
							if (has_byte) begin
								state_d = fnvbf_pkg::S_HASH;
							end else if (last) begin
								state_d = fnvbf_pkg::S_MIX;
							end
						end
					endcase
				end
			end
			fnvbf_pkg::S_HASH: state_d = last_q ? fnvbf_pkg::S_MIX : fnvbf_pkg::S_IDLE;
			fnvbf_pkg::S_MIX: begin
				if (mix_end) begin
					if (!phase_q) begin
						state_d = (n_eff == '0) ? fnvbf_pkg::S_DONE : fnvbf_pkg::S_MULB;
					end else begin
						state_d = (k_eff == '0) ? fnvbf_pkg::S_DONE : fnvbf_pkg::S_MOD;
					end
				end
			end
			fnvbf_pkg::S_MULB: state_d = fnvbf_pkg::S_MIX;
			fnvbf_pkg::S_MOD: begin
				if (mod_rsp.done) begin
					state_d = fnvbf_pkg::S_RD;
				end
			end
			fnvbf_pkg::S_RD: state_d = fnvbf_pkg::S_RDW;
			fnvbf_pkg::S_RDW: state_d = probe_end ? fnvbf_pkg::S_DONE : fnvbf_pkg::S_MOD;
			fnvbf_pkg::S_WRD: state_d = fnvbf_pkg::S_DONE;
			fnvbf_pkg::S_DONE: begin
				if (out_free) begin
					state_d = fnvbf_pkg::S_IDLE;
				end
			end
			default: state_d = fnvbf_pkg::S_IDLE;
		endcase
	end

	// control outputs: handshake, store port, remainder unit
	always_comb begin
		in_ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = x_q[15:5];
		ram_wdata = ram_rdata | mask;
		ram_raddr = x_q[15:5];
		mod_req.start = 1'b0;
		mod_req.dividend = a_q;
		mod_req.divisor = n_eff;
		unique case (state_q)
			fnvbf_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			fnvbf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				ram_raddr = word_index;
				ram_waddr = word_index;
				ram_wdata = word_value;
				ram_we = in_valid && (kind == fnvbf_pkg::KIND_WRITE);
			end
			fnvbf_pkg::S_MIX: begin
				mod_req.start = mix_end && phase_q && (k_eff != '0);
			end
			fnvbf_pkg::S_RDW: begin
				ram_we = kind_q == fnvbf_pkg::KIND_ADD;
				mod_req.start = !probe_end;
				mod_req.dividend = {16'd0, x_q} + b_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnvbf_pkg::S_CLEAR;
			clr_q <= '0;
			acc_q <= fnvbf_pkg::FNV_BASIS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fnvbf_pkg::S_CLEAR) begin
				clr_q <= clr_q + 11'd1;
			end
			if (in_acc && !kind[1] && !has_byte && last) begin
				acc_q <= fnvbf_pkg::FNV_BASIS;
			end
			if (state_q == fnvbf_pkg::S_HASH) begin
				acc_q <= last_q ? fnvbf_pkg::FNV_BASIS : prod;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == fnvbf_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// hashing and probe datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			fnvbf_pkg::S_IDLE: begin
				kind_q <= kind;
				last_q <= last;
				mul_in_q <= acc_q ^ ext;
				val_q <= acc_q;
				rnd_q <= '0;
				phase_q <= 1'b0;
			end
			fnvbf_pkg::S_HASH: begin
				val_q <= prod;
				rnd_q <= '0;
			end
			fnvbf_pkg::S_MIX: begin
				val_q <= mixed;
				rnd_q <= rnd_q + 3'd1;
				if (mix_end) begin
					if (!phase_q) begin
						a_q <= mixed;
						mul_in_q <= mixed;
						present_q <= 1'b0;
					end else begin
						b_q <= mixed;
						present_q <= 1'b1;
						probe_q <= '0;
					end
				end
			end
			fnvbf_pkg::S_MULB: begin
				val_q <= prod;
				rnd_q <= '0;
				phase_q <= 1'b1;
			end
			fnvbf_pkg::S_MOD: begin
				x_q <= mod_rsp.rem;
			end
			fnvbf_pkg::S_RDW: begin
				probe_q <= probe_q + 5'd1;
				if ((ram_rdata & mask) == '0) begin
					present_q <= 1'b0;
				end
			end
			fnvbf_pkg::S_WRD: begin
				word_q <= ram_rdata;
				kind_q <= fnvbf_pkg::ANS_READ;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == fnvbf_pkg::S_DONE && out_free) begin
			answer_kind_q <= kind_q;
			present_out_q <= (kind_q == fnvbf_pkg::ANS_TEST) && present_q;
			read_word_q <= (kind_q == fnvbf_pkg::ANS_READ) ? word_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign answer_kind = answer_kind_q;
	assign probably_present = present_out_q;
	assign read_word = read_word_q;

	fnvbf_mod u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.req(mod_req),
		.rsp(mod_rsp)
	);

	fnvbf_ram #(
		.WIDTH(32),
		.DEPTH(fnvbf_pkg::STORE_WORDS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`BFD_ASSERT(a_mod_done_in_mod, clk, arst_n, mod_rsp.done |-> (state_q == fnvbf_pkg::S_MOD))
	`BFD_ASSERT(a_rem_in_range, clk, arst_n, mod_rsp.done |-> ({1'b0, mod_rsp.rem} < n_eff))
	`BFD_ASSERT(a_probe_bound, clk, arst_n, (state_q == fnvbf_pkg::S_RDW) |-> (probe_q < k_eff))
	`BFD_ASSERT(a_no_take_clear, clk, arst_n, (state_q == fnvbf_pkg::S_CLEAR) |=> !$past(in_acc))

endmodule

/* tb/bloom_filter_fnv_double_hash_tb.sv */
// Testbench for the FNV double-hash Bloom filter: directed and random key, word-write
// and word-read transactions, checked against an in-bench predictor of the filter.
// Depends on fnvbf_pkg and the bloom_filter_fnv_double_hash RTL.
module bloom_filter_fnv_double_hash_tb;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 700;

	typedef struct packed {
		logic [1:0]  akind;
		logic        present;
		logic [31:0] word;
	} answer_t;

	// predictor of the filter plus queue of answers still owed by the block
	class bloom_scoreboard;
		logic [31:0] store [fnvbf_pkg::STORE_WORDS];
		logic [31:0] acc;
		logic [16:0] nbits;
		logic [4:0]  nhash;
		answer_t     owed [$];
		int          errors;
		int          checked;
		int          positives;

		function new();
			foreach (store[i]) store[i] = '0;
			acc = fnvbf_pkg::FNV_BASIS;
			nbits = '0;
			nhash = 5'd1;
			errors = 0;
			checked = 0;
			positives = 0;
		endfunction

		function void set_reg(logic idx, logic [16:0] data);
			if (idx == fnvbf_pkg::CFG_BIT_COUNT)
				nbits = data;
			else
				nhash = data[4:0];
		endfunction

		function logic [31:0] mix(logic [31:0] v);
			v = v + (v << 13);
			v = v ^ (v >> 7);
			v = v + (v << 3);
			v = v ^ (v >> 17);
			v = v + (v << 5);
			return v;
		endfunction

		// double-hash probes; sets bits on add, reports all-set on test
		function logic probe(logic [31:0] a, logic setting);
			logic [31:0] n, b, x, k;
			logic all_set;
			n = {15'd0, (nbits > fnvbf_pkg::MAX_BITS) ? fnvbf_pkg::MAX_BITS : nbits};
			k = {27'd0, (nhash > fnvbf_pkg::MAX_HASHES) ? fnvbf_pkg::MAX_HASHES : nhash};
			all_set = 1'b1;
			if (n == 0)
				return 1'b0;
			b = mix(a * fnvbf_pkg::FNV_PRIME);
			x = a % n;
			for (int i = 0; i < k; i++) begin
				if (setting)
					store[x[15:5]][x[4:0]] = 1'b1;
				else if (!store[x[15:5]][x[4:0]])
					all_set = 1'b0;
				x = (x + b) % n;
			end
			return all_set;
		endfunction

		function void note_item(logic [1:0] k, logic [7:0] kb, logic hb, logic lst,
				logic [10:0] idx, logic [31:0] val);
			answer_t ans;
			logic hit;
			ans = '0;
			if (k == fnvbf_pkg::KIND_WRITE) begin
				store[idx] = val;
				return;
			end
			if (k == fnvbf_pkg::KIND_READ) begin
				ans.akind = fnvbf_pkg::ANS_READ;
				ans.word = store[idx];
				owed.push_back(ans);
				return;
			end
			if (hb)
				acc = (acc ^ {{24{kb[7]}}, kb}) * fnvbf_pkg::FNV_PRIME;
			if (!lst)
				return;
			hit = probe(mix(acc), k == fnvbf_pkg::KIND_ADD);
			acc = fnvbf_pkg::FNV_BASIS;
			ans.akind = k;
			ans.present = (k == fnvbf_pkg::KIND_TEST) && hit;
			if (ans.present)
				positives++;
			owed.push_back(ans);
		endfunction

		function void check_answer(logic [1:0] ak, logic pp, logic [31:0] rw);
			answer_t exp_ans;
			if (owed.size() == 0) begin
				$error("unexpected result: answer_kind=%0d", ak);
				errors++;
				return;
			end
			exp_ans = owed.pop_front();
			checked++;
			if (ak !== exp_ans.akind) begin
				$error("answer_kind: expected %0d, got %0d", exp_ans.akind, ak);
				errors++;
			end
			if (pp !== exp_ans.present) begin
				$error("probably_present: expected %0d, got %0d", exp_ans.present, pp);
				errors++;
			end
			if (rw !== exp_ans.word) begin
				$error("read_word: expected %08h, got %08h", exp_ans.word, rw);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [16:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  key_byte;
	logic        has_byte;
	logic        last;
	logic [10:0] word_index;
	logic [31:0] word_value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  answer_kind;
	logic        probably_present;
	logic [31:0] read_word;

	bloom_filter_fnv_double_hash u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .key_byte(key_byte), .has_byte(has_byte), .last(last),
		.word_index(word_index), .word_value(word_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.answer_kind(answer_kind), .probably_present(probably_present),
		.read_word(read_word)
	);

	bloom_scoreboard filter_sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int cycle_count;
	int items_sent;
	logic [63:0] key_bank [$];
	int          key_len_bank [$];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// global watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		int hold_left;
		if (out_valid && out_ready)
			filter_sb.check_answer(answer_kind, probably_present, read_word);
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 4000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic idx, logic [16:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		filter_sb.set_reg(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// one input transaction, with optional idle cycles before it
	task automatic send_item(logic [1:0] k, logic [7:0] kb, logic hb, logic lst,
			logic [10:0] idx, logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key_byte <= kb;
		has_byte <= hb;
		last <= lst;
		word_index <= idx;
		word_value <= val;
		do @(posedge clk); while (!in_ready);
		filter_sb.note_item(k, kb, hb, lst, idx, val);
		items_sent++;
	endtask

	// whole key; an empty key is one transaction with has_byte low
	task automatic send_key(logic [1:0] k, logic [63:0] bytes, int len, bit mixed);
		logic [1:0] ik;
		if (len == 0) begin
			send_item(k, 8'($urandom), 1'b0, 1'b1, 11'($urandom), $urandom);
			return;
		end
		for (int i = 0; i < len; i++) begin
			ik = (mixed && i != len - 1) ? 2'($urandom_range(1)) : k;
			send_item(ik, bytes[8*i +: 8], 1'b1, i == len - 1, 11'($urandom), $urandom);
			// stray byte-less transaction inside a key
			if (i != len - 1 && $urandom_range(19) == 0)
				send_item(ik, 8'($urandom), 1'b0, 1'b0, 11'($urandom), $urandom);
		end
	endtask

	// wait for all owed answers, then let the block finish any silent work
	task automatic drain();
		in_valid <= 1'b0;
		while (filter_sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [63:0] bytes;
		int len, pick, sel;
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// test a remembered key about half the time
				if (key_bank.size() != 0 && $urandom_range(1) == 1) begin
					sel = $urandom_range(key_bank.size() - 1);
					send_key(fnvbf_pkg::KIND_TEST, key_bank[sel], key_len_bank[sel], 1'b0);
				end else begin
					bytes = {$urandom, $urandom};
					len = $urandom_range(6);
					send_key(2'($urandom_range(1)), bytes, len, $urandom_range(9) == 0);
					key_bank.push_back(bytes);
					key_len_bank.push_back(len);
					if (key_bank.size() > 32) begin
						void'(key_bank.pop_front());
						void'(key_len_bank.pop_front());
					end
				end
			end else if (pick < 82) begin
				send_item(fnvbf_pkg::KIND_WRITE, 8'($urandom), 1'($urandom), 1'($urandom),
					11'($urandom), $urandom);
			end else begin
				send_item(fnvbf_pkg::KIND_READ, 8'($urandom), 1'($urandom), 1'($urandom),
					11'($urandom), $urandom);
			end
		end
	endtask

	task automatic random_config();
		logic [16:0] nb;
		logic [4:0] nh;
		case ($urandom_range(5))
			0: nb = 17'd1;
			1: nb = 17'd65536;
			2: nb = 17'h1FFFF;
			3: nb = 17'($urandom_range(64, 4096));
			default: nb = 17'($urandom_range(1, 65536));
		endcase
		nh = ($urandom_range(4) == 0) ? 5'd31 : 5'($urandom_range(1, 8));
		write_reg(fnvbf_pkg::CFG_BIT_COUNT, nb);
		write_reg(fnvbf_pkg::CFG_HASH_COUNT, {12'd0, nh});
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = fnvbf_pkg::KIND_ADD;
		key_byte = '0;
		has_byte = 1'b0;
		last = 1'b0;
		word_index = '0;
		word_value = '0;
		out_ready = 1'b0;
		hold_request = 1'b0;
		cycle_count = 0;
		items_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of bytes, empty key, word items, special settings
		write_reg(fnvbf_pkg::CFG_BIT_COUNT, 17'd1000);
		write_reg(fnvbf_pkg::CFG_HASH_COUNT, 17'd4);
		send_key(fnvbf_pkg::KIND_ADD, 64'h0, 0, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'h0, 0, 1'b0);
		send_key(fnvbf_pkg::KIND_ADD, 64'h7F80FF00, 4, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'h7F80FF00, 4, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'h01, 1, 1'b0);
		send_item(fnvbf_pkg::KIND_ADD, 8'h41, 1'b1, 1'b0, '0, '0);
		send_item(fnvbf_pkg::KIND_TEST, 8'hC3, 1'b1, 1'b1, '1, '1);
		send_item(fnvbf_pkg::KIND_WRITE, '0, 1'b0, 1'b0, 11'd0, 32'hFFFF_FFFF);
		send_item(fnvbf_pkg::KIND_WRITE, '1, 1'b1, 1'b1, 11'd2047, 32'hA5A5_5A5A);
		send_item(fnvbf_pkg::KIND_READ, '0, 1'b0, 1'b0, 11'd0, '0);
		send_item(fnvbf_pkg::KIND_READ, '0, 1'b0, 1'b0, 11'd2047, '0);
		send_item(fnvbf_pkg::KIND_READ, '0, 1'b0, 1'b0, 11'd5, '0);
		drain();
		write_reg(fnvbf_pkg::CFG_BIT_COUNT, 17'd0);
		send_key(fnvbf_pkg::KIND_ADD, 64'h55, 1, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'h55, 1, 1'b0);
		drain();
		write_reg(fnvbf_pkg::CFG_BIT_COUNT, 17'd500);
		write_reg(fnvbf_pkg::CFG_HASH_COUNT, 17'd0);
		send_key(fnvbf_pkg::KIND_ADD, 64'h99, 1, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'h99, 1, 1'b0);
		drain();
		write_reg(fnvbf_pkg::CFG_BIT_COUNT, 17'h1FFFF);
		write_reg(fnvbf_pkg::CFG_HASH_COUNT, 17'd31);
		send_key(fnvbf_pkg::KIND_ADD, 64'h1234, 2, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'h1234, 2, 1'b0);
		drain();
		write_reg(fnvbf_pkg::CFG_BIT_COUNT, 17'd1);
		write_reg(fnvbf_pkg::CFG_HASH_COUNT, 17'd1);
		send_key(fnvbf_pkg::KIND_ADD, 64'hAB, 1, 1'b0);
		send_key(fnvbf_pkg::KIND_TEST, 64'hCD, 1, 1'b0);
		drain();

		// random phases under changing stall patterns
		send_idle_pct = 26;
		recv_idle_pct = 49;
		random_config();
		random_phase(330);
		drain();

		// long result stall while reads keep coming, to back up the input
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(fnvbf_pkg::KIND_READ, 8'($urandom), 1'($urandom), 1'($urandom),
				11'($urandom), $urandom);
		drain();

		send_idle_pct = 49;
		recv_idle_pct = 26;
		random_config();
		random_phase(330);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_config();
		random_phase(330);
		drain();

		$display("covered %0d input transactions, %0d results checked, %0d positive tests",
			items_sent, filter_sb.checked, filter_sb.positives);
		if (filter_sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/fnvbf_pkg.sv
sv/fnvbf_ram.sv
sv/fnvbf_mod.sv
sv/bloom_filter_fnv_double_hash.sv
tb/bloom_filter_fnv_double_hash_tb.sv
